// ===== rtl/core/motion_triggered_camera_selector_assert.svh =====
// ----------------------------------------------------------------------------
// motion_triggered_camera_selector_assert.svh
// assertion macros used by the camera selector engine
// ----------------------------------------------------------------------------
`ifndef MOTION_TRIGGERED_CAMERA_SELECTOR_ASSERT_SVH
`define MOTION_TRIGGERED_CAMERA_SELECTOR_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define MTCS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// condition that must hold whenever the antecedent holds
`define MTCS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mtcs_pkg.sv =====
// ----------------------------------------------------------------------------
// mtcs_pkg
// shared constants, codes and types of the camera selector
// ----------------------------------------------------------------------------
package mtcs_pkg;

  // default sizes
  localparam int DEF_NUM_CAMERAS = 4;
  localparam int DEF_COUNT_WIDTH = 16;

  // configuration register layout
  localparam int CFG_WIDTH      = 16;
  localparam int APB_ADDR_WIDTH = 3;
  localparam int APB_DATA_WIDTH = 32;
  localparam int REG_ADDR_LSB   = 2;

  localparam logic [CFG_WIDTH-1:0] HOLD_TICKS_RESET  = 16'd500;
  localparam logic [CFG_WIDTH-1:0] DWELL_TICKS_RESET = 16'd300;

  // register indexes
  localparam logic REG_HOLD_TICKS  = 1'b0;
  localparam logic REG_DWELL_TICKS = 1'b1;

  // recording mode, unset only before the first transaction
  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_ROTATE = 2'd2,
    MODE_UNSET  = 2'd3
  } mode_t;

  // configuration handed from the register block to the engine
  typedef struct packed {
    logic [CFG_WIDTH-1:0] hold_ticks;
    logic [CFG_WIDTH-1:0] dwell_ticks;
  } cfg_t;

endpackage

// ===== rtl/core/mtcs_if.sv =====
// ----------------------------------------------------------------------------
// mtcs_if
// valid/ready channels for sensor samples and selector results
// ----------------------------------------------------------------------------

// sensor sample channel
interface mtcs_in_if
  import mtcs_pkg::*;
#(
  parameter int NUM_CAMERAS = DEF_NUM_CAMERAS
);
  logic                   valid;
  logic                   ready;
  logic [NUM_CAMERAS-1:0] sensors;
  logic                   tick;

  modport source (output valid, output sensors, output tick, input ready);
  modport sink   (input valid, input sensors, input tick, output ready);
endinterface

// selector result channel
interface mtcs_out_if
  import mtcs_pkg::*;
#(
  parameter int NUM_CAMERAS = DEF_NUM_CAMERAS,
  parameter int SEL_W       = $clog2(NUM_CAMERAS)
);
  logic                   valid;
  logic                   ready;
  logic [SEL_W-1:0]       camera_select;
  logic                   pause;
  logic [1:0]             mode;
  logic [NUM_CAMERAS-1:0] marked_mask;
  logic                   announce;

  modport source (output valid, output camera_select, output pause, output mode,
                  output marked_mask, output announce, input ready);
  modport sink   (input valid, input camera_select, input pause, input mode,
                  input marked_mask, input announce, output ready);
endinterface

// ===== rtl/core/mtcs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mtcs_cfg_regs
// apb register block holding the hold and dwell thresholds
// ----------------------------------------------------------------------------
module mtcs_cfg_regs
  import mtcs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready,
  output cfg_t                      cfg
);

  logic reg_index;
  logic wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[REG_ADDR_LSB];
  assign wr_en     = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_ticks  <= HOLD_TICKS_RESET;
      cfg.dwell_ticks <= DWELL_TICKS_RESET;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_HOLD_TICKS:  cfg.hold_ticks  <= pwdata[CFG_WIDTH-1:0];
        REG_DWELL_TICKS: cfg.dwell_ticks <= pwdata[CFG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_index)
      REG_HOLD_TICKS:  prdata = APB_DATA_WIDTH'(cfg.hold_ticks);
      REG_DWELL_TICKS: prdata = APB_DATA_WIDTH'(cfg.dwell_ticks);
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/mtcs_engine.sv =====
// ----------------------------------------------------------------------------
// mtcs_engine
// input register, per-sample selection logic and result register
// ----------------------------------------------------------------------------
module mtcs_engine
  import mtcs_pkg::*;
#(
  parameter int NUM_CAMERAS = DEF_NUM_CAMERAS,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
)(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  mtcs_in_if.sink          items,
  mtcs_out_if.source       results
);

  `include "motion_triggered_camera_selector_assert.svh"

  localparam int SEL_W = $clog2(NUM_CAMERAS);
  localparam int SUM_W = SEL_W + 1;
  localparam int ANN_W = $clog2(NUM_CAMERAS + 1);
  localparam int CMP_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
  localparam logic [ANN_W-1:0] NONE_ANNOUNCED = ANN_W'(NUM_CAMERAS);

  // input register
  logic                   in_valid;
  logic [NUM_CAMERAS-1:0] in_sensors;
  logic                   in_tick;
  logic                   advance;

  // selector state
  logic [NUM_CAMERAS-1:0] active_flag;
  logic [NUM_CAMERAS-1:0] marked_flag;
  logic [COUNT_WIDTH-1:0] hold_count [NUM_CAMERAS];
  logic [COUNT_WIDTH-1:0] dwell_count;
  logic [SEL_W-1:0]       current_camera;
  logic                   rotate_enable;
  mode_t                  previous_mode;
  logic [ANN_W-1:0]       announced_camera;

  // next state
  logic [NUM_CAMERAS-1:0] active_flag_next;
  logic [NUM_CAMERAS-1:0] marked_flag_next;
  logic [COUNT_WIDTH-1:0] hold_count_next [NUM_CAMERAS];
  logic [COUNT_WIDTH-1:0] dwell_count_next;
  logic [SEL_W-1:0]       current_camera_next;
  logic                   rotate_enable_next;
  logic [ANN_W-1:0]       announced_camera_next;
  mode_t                  mode_cur;
  logic                   announce_cur;
  logic [SEL_W-1:0]       lowest;
  logic [SEL_W-1:0]       rot_pick;
  logic [SUM_W-1:0]       cand_sum;
  logic [SEL_W-1:0]       cand;
  logic                   entering;

  // result register
  logic                   out_valid;
  logic [SEL_W-1:0]       out_camera_select;
  logic                   out_pause;
  mode_t                  out_mode;
  logic [NUM_CAMERAS-1:0] out_marked_mask;
  logic                   out_announce;

  // handshake: advance when the result register is free or being drained
  assign advance     = in_valid && (!out_valid || results.ready);
  assign items.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (items.ready) begin
      in_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      in_sensors <= items.sensors;
      in_tick    <= items.tick;
    end
  end

  // sensor edges, tick, mode evaluation
  always_comb begin
    active_flag_next      = in_sensors;
    marked_flag_next      = marked_flag | (in_sensors & ~active_flag);
    dwell_count_next      = dwell_count;
    current_camera_next   = current_camera;
    rotate_enable_next    = rotate_enable;
    announced_camera_next = announced_camera;
    announce_cur          = 1'b0;
    rot_pick              = current_camera;
    cand_sum              = '0;
    cand                  = '0;
    lowest                = '0;
    entering              = 1'b0;

    for (int k = 0; k < NUM_CAMERAS; k++) begin
      hold_count_next[k] = (!in_sensors[k] && active_flag[k]) ? '0 : hold_count[k];
    end

    if (in_tick) begin
      dwell_count_next = (&dwell_count) ? dwell_count : dwell_count + 1'b1;
      for (int k = 0; k < NUM_CAMERAS; k++) begin
        hold_count_next[k] = (&hold_count_next[k]) ? hold_count_next[k]
                                                   : hold_count_next[k] + 1'b1;
        if (!active_flag_next[k] &&
            CMP_W'(hold_count_next[k]) >= CMP_W'(cfg.hold_ticks)) begin
          marked_flag_next[k] = 1'b0;
        end
      end
      // rotation: nearest marked camera after the current one
      if (rotate_enable && CMP_W'(dwell_count_next) >= CMP_W'(cfg.dwell_ticks)) begin
        for (int step = NUM_CAMERAS; step >= 1; step--) begin
          cand_sum = SUM_W'(current_camera) + SUM_W'(step);
          cand     = (cand_sum >= SUM_W'(NUM_CAMERAS)) ?
                     SEL_W'(cand_sum - SUM_W'(NUM_CAMERAS)) : SEL_W'(cand_sum);
          if (marked_flag_next[cand]) begin
            rot_pick = cand;
          end
        end
        current_camera_next = rot_pick;
        dwell_count_next    = '0;
      end
    end

    // lowest marked camera
    for (int k = NUM_CAMERAS - 1; k >= 0; k--) begin
      if (marked_flag_next[k]) begin
        lowest = SEL_W'(k);
      end
    end

    priority if (marked_flag_next == '0) begin
      mode_cur = MODE_NONE;
    end else if ($onehot(marked_flag_next)) begin
      mode_cur = MODE_SINGLE;
    end else begin
      mode_cur = MODE_ROTATE;
    end

    // mode entry and announce
    if (mode_cur == MODE_NONE) begin
      if (previous_mode != MODE_NONE) begin
        rotate_enable_next    = 1'b0;
        announce_cur          = 1'b1;
        announced_camera_next = NONE_ANNOUNCED;
      end
    end else begin
      entering = (previous_mode != mode_cur);
      if (entering) begin
        current_camera_next = lowest;
        if (mode_cur == MODE_SINGLE) begin
          rotate_enable_next = 1'b0;
        end else begin
          dwell_count_next   = '0;
          rotate_enable_next = 1'b1;
        end
      end
      if (entering || mode_cur == MODE_ROTATE) begin
        if (announced_camera != ANN_W'(current_camera_next)) begin
          announce_cur          = 1'b1;
          announced_camera_next = ANN_W'(current_camera_next);
        end
      end
    end
  end

  // state update on each processed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      active_flag      <= '0;
      marked_flag      <= '0;
      dwell_count      <= '0;
      current_camera   <= '0;
      rotate_enable    <= 1'b0;
      previous_mode    <= MODE_UNSET;
      announced_camera <= NONE_ANNOUNCED;
      for (int k = 0; k < NUM_CAMERAS; k++) begin
        hold_count[k] <= '0;
      end
    end else if (advance) begin
      active_flag      <= active_flag_next;
      marked_flag      <= marked_flag_next;
      dwell_count      <= dwell_count_next;
      current_camera   <= current_camera_next;
      rotate_enable    <= rotate_enable_next;
      previous_mode    <= mode_cur;
      announced_camera <= announced_camera_next;
      for (int k = 0; k < NUM_CAMERAS; k++) begin
        hold_count[k] <= hold_count_next[k];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_camera_select <= current_camera_next;
      out_pause         <= (mode_cur == MODE_NONE);
      out_mode          <= mode_cur;
      out_marked_mask   <= marked_flag_next;
      out_announce      <= announce_cur;
    end
  end

  assign results.valid         = out_valid;
  assign results.camera_select = out_camera_select;
  assign results.pause         = out_pause;
  assign results.mode          = out_mode;
  assign results.marked_mask   = out_marked_mask;
  assign results.announce      = out_announce;

  // checks
  `MTCS_ASSERT_ALWAYS(a_active_is_marked, (active_flag & ~marked_flag) == '0,
    "active camera is not marked")
  `MTCS_ASSERT_IMPLIES(a_rotate_only_in_rotate_mode, rotate_enable,
    previous_mode == MODE_ROTATE, "rotation enabled outside rotating mode")
  `MTCS_ASSERT_IMPLIES(a_none_forgets_announce, previous_mode == MODE_NONE,
    announced_camera == NONE_ANNOUNCED, "announced camera kept while paused")
  `MTCS_ASSERT_IMPLIES(a_paused_result_empty, out_valid && out_mode == MODE_NONE,
    out_pause && out_marked_mask == '0, "paused result carries marked cameras")

endmodule

// ===== rtl/core/motion_triggered_camera_selector.sv =====
// ----------------------------------------------------------------------------
// motion_triggered_camera_selector
// picks the camera to record from presence sensor samples
// ----------------------------------------------------------------------------
// Usage:
//   items carries one sensor sample per transaction: sensors (bit k for camera
//   k) and tick, one time base tick. results returns exactly one transaction
//   per sample: camera_select, pause, mode, marked_mask and an announce pulse.
//   hold_ticks (address 0) and dwell_ticks (address 4) are set through the apb
//   port; write them only while no sample is in flight.
// Pipeline and throughput:
//   a sample lands in the input register, is evaluated against the selector
//   state in one pass and its result is written into the result register
//   once that register is free or being drained. One sample is taken every
//   cycle while results is ready; the state update of the single evaluation
//   stage sets that.
// Reset:
//   rst clears all marks, counters and the announce history, loads the
//   threshold defaults (500 and 300) and empties both registers.
// Stall:
//   while results is not ready, the result register holds its transaction,
//   one more sample waits in the input register and then items.ready drops.
// ----------------------------------------------------------------------------
module motion_triggered_camera_selector
  import mtcs_pkg::*;
#(
  parameter int NUM_CAMERAS = DEF_NUM_CAMERAS,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
)(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready,
  mtcs_in_if.sink                   items,
  mtcs_out_if.source                results
);

  cfg_t cfg;

  // threshold registers
  mtcs_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // selection pipeline
  mtcs_engine #(
    .NUM_CAMERAS (NUM_CAMERAS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .items   (items),
    .results (results)
  );

endmodule
